// ===== design/aes_pkg.sv =====
// Shared types, constants and round functions for the AES block engine.
package aes_pkg;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_ENCRYPT = 2'd1,
        OP_DECRYPT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_KEY   = 2'd1,
        ST_ROUND = 2'd2,
        ST_OUT   = 2'd3
    } state_t;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [3:0] NR_128 = 4'd10;
    localparam logic [3:0] NR_192 = 4'd12;
    localparam logic [3:0] NR_256 = 4'd14;

    // Round unit control from the sequencer.
    typedef struct packed {
        logic decrypt;
        logic last;
    } round_ctl_t;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ p;
            p = xt(p);
        end
        gmul = r;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] p;
        logic [7:0] e;
        r = 8'h01;
        p = x;
        e = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = gmul(r, p);
            p = gmul(p, p);
        end
        ginv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
        rotl8 = 8'((b << n) | (b >> (8 - n)));
    endfunction

    function automatic logic [7:0] sbox_f(input logic [7:0] x);
        logic [7:0] b;
        b = ginv(x);
        sbox_f = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_f(input logic [7:0] x);
        inv_sbox_f = ginv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
    endfunction

endpackage

// ===== design/aes_round.sv =====
// One AES round (forward or inverse) with round key add; shared every cycle.
module aes_round import aes_pkg::*; (
    input  round_ctl_t     ctl,
    input  logic [127:0]   state_in,
    input  logic [127:0]   round_key,
    output logic [127:0]   state_out
);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] sb_tab  [256];
    logic [7:0] isb_tab [256];

    // Byte lookup tables, built as constants.
    always_comb begin
        for (int i = 0; i < 256; i++) begin
            sb_tab[i]  = sbox_f(8'(i));
            isb_tab[i] = inv_sbox_f(8'(i));
        end
    end

    // SubBytes/ShiftRows and inverses, then MixColumns or its inverse except in the last round, then round key add
    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = state_in[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (ctl.decrypt) t[r + 4*((c + r) & 3)] = isb_tab[s[r + 4*c]];
                else             t[r + 4*c] = sb_tab[s[r + 4*((c + r) & 3)]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (ctl.last) begin
                    m[4*c + r] = t[4*c + r];
                end else if (ctl.decrypt) begin
                    m[4*c + r] = gmul(t[4*c + r], 8'd14) ^ gmul(t[4*c + ((r+1)&3)], 8'd11)
                               ^ gmul(t[4*c + ((r+2)&3)], 8'd13)
                               ^ gmul(t[4*c + ((r+3)&3)], 8'd9);
                end else begin
                    m[4*c + r] = xt(t[4*c + r]) ^ xt(t[4*c + ((r+1)&3)])
                               ^ t[4*c + ((r+1)&3)] ^ t[4*c + ((r+2)&3)]
                               ^ t[4*c + ((r+3)&3)];
                end
            end
        end
        for (int i = 0; i < 16; i++) state_out[127 - 8*i -: 8] = m[i] ^ round_key[127 - 8*i -: 8];
    end
endmodule

// ===== design/aes_block_encrypt_decrypt_top.sv =====
// Top level: key table, round sequencer and output register of the AES engine.
// During a key load s_tready stays high, so loads can follow back to back.
// Encrypt/decrypt: the first key is read at the accepting edge, then ST_KEY does the initial
// key add and ST_ROUND runs one round-unit pass per round before the result is valid in ST_OUT.
// s_tready is low until the result leaves, so a new block is only taken once the last has left.
// aresetn (synchronous, active low) clears control and key_size; keys stay undefined.
module aes_block_encrypt_decrypt_top import aes_pkg::*; #(
    parameter int KEY_TABLE_DEPTH = 15
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tuser,   // [1:0] op, [7:2] zero
    input  logic [135:0] s_tdata,   // [3:0] key_index, [67:4] data_high, [131:68] data_low
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] result_high, [127:64] result_low
);
    localparam int IW = (KEY_TABLE_DEPTH > 1) ? $clog2(KEY_TABLE_DEPTH) : 1;

    state_t        state_reg, state_next;
    logic [1:0]    key_size_reg;
    logic          dec_reg, dec_next;
    logic [3:0]    rnd_reg, rnd_next;
    logic [3:0]    nr;
    logic [127:0]  blk_reg, blk_next;
    logic [127:0]  key_rd_reg;
    logic [127:0]  key_mem [KEY_TABLE_DEPTH];
    logic [3:0]    rd_idx;
    logic [127:0]  round_out;
    round_ctl_t    ctl;
    logic          in_fire;
    op_t           op;

    assign op      = op_t'(s_tuser[1:0]);
    assign in_fire = s_tvalid && s_tready;
    assign nr      = (key_size_reg == KS_128) ? NR_128 :
                     (key_size_reg == KS_192) ? NR_192 : NR_256;

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) key_size_reg <= KS_128;
        else if (cfg_we) key_size_reg <= cfg_wdata;
    end

    // Key index for the next read: the round the next cycle will use
    always_comb begin
        if (state_reg == ST_IDLE) rd_idx = (op == OP_DECRYPT) ? nr : 4'd0;
        else rd_idx = rnd_next;
    end

    // Key table, registered read; slots past the table read zero
    always_ff @(posedge aclk) begin
        if (in_fire && op == OP_LOAD && 32'(s_tdata[3:0]) < KEY_TABLE_DEPTH)
            key_mem[s_tdata[IW-1:0]] <= {s_tdata[67:4], s_tdata[131:68]};
        if (32'(rd_idx) < KEY_TABLE_DEPTH) key_rd_reg <= key_mem[rd_idx[IW-1:0]];
        else key_rd_reg <= '0;
    end

    assign ctl.decrypt = dec_reg;
    assign ctl.last    = dec_reg ? (rnd_reg == 4'd0) : (rnd_reg == nr);

    aes_round u_round (
        .ctl       (ctl),
        .state_in  (blk_reg),
        .round_key (key_rd_reg),
        .state_out (round_out)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire && (op == OP_ENCRYPT || op == OP_DECRYPT)) state_next = ST_KEY;
            ST_KEY:   state_next = ST_ROUND;
            ST_ROUND: if (ctl.last) state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and round counter
    always_comb begin
        dec_next = dec_reg;
        rnd_next = rnd_reg;
        blk_next = blk_reg;
        case (state_reg)
            ST_IDLE: begin
                dec_next = (op == OP_DECRYPT);
                blk_next = {s_tdata[67:4], s_tdata[131:68]};
                rnd_next = (op == OP_DECRYPT) ? nr : 4'd0;
            end
            ST_KEY: begin
                blk_next = blk_reg ^ key_rd_reg;
                rnd_next = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
            end
            ST_ROUND: begin
                blk_next = round_out;
                if (!ctl.last) rnd_next = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dec_reg   <= 1'b0;
            rnd_reg   <= 4'd0;
        end else begin
            state_reg <= state_next;
            dec_reg   <= dec_next;
            rnd_reg   <= rnd_next;
        end
        blk_reg <= blk_next;
    end

    // Outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = {blk_reg[63:0], blk_reg[127:64]};
    end

`ifndef ASSERT_OFF
    a_out_after_round: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_ROUND) else $error("result without round");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready while result pending");
    a_rnd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND |-> rnd_reg <= nr) else $error("round count out of range");
`endif
endmodule
